// File: src/oile_pkg.sv
// ----------------------------------------------------------------------------
// oile_pkg
// Shared types and codes for the ordered integer list engine.
// ----------------------------------------------------------------------------
package oile_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 32;
  localparam int COUNT_OUT_W   = 6;

  // request opcodes
  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_INSERT   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_REMOVE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // per-cell load selects, applied in the commit cycle
  typedef struct packed {
    logic take_value;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// File: src/oile_cell.sv
// ----------------------------------------------------------------------------
// oile_cell
// One list position: holds an entry, flags a hit against the request value,
// and loads from the request, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module oile_cell (
  input  logic                              clk,
  input  logic                              occupied,
  input  logic                              at_tail,
  input  logic [1:0]                        opcode,
  input  logic signed [oile_pkg::DATA_W-1:0] value,
  input  oile_pkg::cell_ctl_t               ctl,
  input  logic [oile_pkg::DATA_W-1:0]       left_entry,
  input  logic [oile_pkg::DATA_W-1:0]       right_entry,
  output logic [oile_pkg::DATA_W-1:0]       entry,
  output logic                              hit
);

  logic below;

  assign below = $signed(entry) < value;

  always_comb begin
    unique case (opcode)
      oile_pkg::OP_APPEND:   hit = at_tail;
      oile_pkg::OP_INSERT:   hit = (occupied && !below) || at_tail;
      oile_pkg::OP_CONTAINS: hit = occupied && (entry == value);
      oile_pkg::OP_REMOVE:   hit = occupied && (entry == value);
      default:               hit = 1'b0;
    endcase
  end

  // most cycles load nothing and the entry holds
  always_ff @(posedge clk) begin
    if (ctl.take_value) begin
      entry <= value;
    end else if (ctl.take_left) begin
      entry <= left_entry;
    end else if (ctl.take_right) begin
      entry <= right_entry;
    end
  end

endmodule

// File: src/ordered_int_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_int_list_engine
// Ordered list of signed 32-bit values kept in a row of cells, with append,
// ordered insert, membership query and remove-first-match requests.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  in      | in_valid / in_ready  | opcode[1:0], value[31:0]
//  out     | out_valid / out_ready| status[1:0], entry_count[5:0]
//
// a request is taken while the engine is idle; in the next cycle every cell
// compares against it and the hits are registered; at the commit that follows,
// the first-hit prefix ripples down the row and, on a write or remove, the cells
// from the first hit onward load at once; each request runs take, compare, commit.
// the commit waits while a previous result sits unread in the output register;
// in_ready comes back the cycle after the commit.
// rst clears the fill count and the handshake state; cell contents are left as is.
module ordered_int_list_engine #(
  parameter int DEPTH = oile_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [oile_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [oile_pkg::COUNT_OUT_W-1:0]  entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic PH_IDLE   = 1'b0;
  localparam logic PH_COMMIT = 1'b1;

  logic                              phase;
  logic                              cmp_ready;
  logic [1:0]                        op_q;
  logic signed [oile_pkg::DATA_W-1:0] value_q;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  logic [DEPTH-1:0]                  hit;
  logic [DEPTH-1:0]                  hit_q;
  logic [DEPTH:0]                    ahead;
  logic [oile_pkg::DATA_W-1:0]       entry [DEPTH];
  oile_pkg::cell_ctl_t               ctl [DEPTH];
  logic                              accept;
  logic                              commit;
  logic                              is_write;
  logic                              full;
  logic                              any_hit;
  logic [1:0]                        status_next;
  logic [CW+oile_pkg::COUNT_OUT_W-1:0] count_ext;

  assign in_ready = (phase == PH_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (phase == PH_COMMIT) && cmp_ready && (!out_valid || out_ready);
  assign is_write = (op_q == oile_pkg::OP_APPEND) || (op_q == oile_pkg::OP_INSERT);
  assign full     = (count == CW'(DEPTH));

  // first-hit prefix passed from cell to cell
  assign ahead[0] = 1'b0;
  assign any_hit  = ahead[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [oile_pkg::DATA_W-1:0] left_entry;
    logic [oile_pkg::DATA_W-1:0] right_entry;

    assign ahead[i+1] = ahead[i] | hit_q[i];

    if (i == 0) begin : g_head
      assign left_entry = entry[i];
    end else begin : g_mid
      assign left_entry = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end

    always_comb begin
      ctl[i].take_value = commit && is_write && !full && hit_q[i] && !ahead[i];
      ctl[i].take_left  = commit && is_write && !full && ahead[i] && (i != 0);
      ctl[i].take_right = commit && (op_q == oile_pkg::OP_REMOVE) && (ahead[i] || hit_q[i]);
    end

    oile_cell u_cell (
      .clk         (clk),
      .occupied    (CW'(i) < count),
      .at_tail     (CW'(i) == count),
      .opcode      (op_q),
      .value       (value_q),
      .ctl         (ctl[i]),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .hit         (hit[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = oile_pkg::ST_OK;
    if (is_write) begin
      if (full) begin
        status_next = oile_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else if (!any_hit) begin
      status_next = oile_pkg::ST_ABSENT;
    end else if (op_q == oile_pkg::OP_REMOVE) begin
      count_next = count - CW'(1);
    end
  end

  assign count_ext = {{oile_pkg::COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= PH_COMMIT;
      end else if (commit) begin
        phase <= PH_IDLE;
      end
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      value_q <= value;
    end
    // compare results are taken the cycle after the request is captured
    if (phase == PH_COMMIT) begin
      hit_q <= hit;
    end
    if (commit) begin
      status      <= status_next;
      entry_count <= count_ext[oile_pkg::COUNT_OUT_W-1:0];
    end
  end

  // hits are registered in the cycle before commit can use them
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_ready <= 1'b0;
    end else begin
      cmp_ready <= (phase == PH_COMMIT) && !commit;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken during commit");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(phase == PH_COMMIT))
    else $error("result without commit");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count == $past(count) - CW'(1)))
    else $error("fill count jumped");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == oile_pkg::ST_OK) || (status == oile_pkg::ST_ABSENT) ||
                  (status == oile_pkg::ST_FULL))
    else $error("unknown status code");

endmodule
